// ===== hdl/csync_pkg.sv =====
// ----------------------------------------------------------------------------
// SYNC service package
// Shared types and constants for the SYNC producer/consumer block.
// ----------------------------------------------------------------------------
`default_nettype none

package csync_pkg;

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_SYNC_COB_ID      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PERIOD_US        = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_COUNTER_OVERFLOW = 2'd2;

  // Configuration data width (widest register).
  localparam int unsigned CFG_DATA_W = 32;

  // Bit positions and limits of the SYNC configuration.
  localparam int unsigned COB_PRODUCER_BIT = 30;
  localparam int unsigned COB_EXTENDED_BIT = 29;
  localparam logic [7:0]  MAX_OVERFLOW     = 8'd240;

  // Reset values.
  localparam logic [31:0] SYNC_COB_ID_RESET = 32'h0000_0080;
  localparam logic [7:0]  SYNC_COUNTER_INIT = 8'd1;

  // Result kinds.
  localparam logic RESULT_SENT     = 1'b0;
  localparam logic RESULT_RECEIVED = 1'b1;

  // Input kinds.
  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_FRAME = 1'b1;

  // One input transaction.
  typedef struct packed {
    logic        kind;
    logic [28:0] frame_id;
    logic        frame_extended;
    logic [3:0]  frame_len;
    logic [7:0]  frame_byte0;
  } item_t;

  // One result transaction.
  typedef struct packed {
    logic        result_kind;
    logic [28:0] out_id;
    logic        out_extended;
    logic        out_len;
    logic [7:0]  counter_value;
    logic        length_error;
  } result_t;

  // Decoded configuration handed from the register file to the core.
  typedef struct packed {
    logic        producer;
    logic        extended;
    logic [28:0] can_id;
    logic [31:0] period;
    logic [7:0]  overflow;
    logic        restart;
  } cfg_t;

endpackage

`default_nettype wire

// ===== hdl/canopen_sync_producer_consumer_top.sv =====
// ----------------------------------------------------------------------------
// SYNC producer/consumer
// Produces SYNC frames from microsecond ticks or consumes received SYNC
// frames, depending on the configured COB-ID.
//
//   Channel   Signals                            Direction
//   item      item_valid, item_stall, item       in  (tick or received frame)
//   result    result_valid, result_stall, result out (sent or received SYNC)
//   config    cfg_we, cfg_index, cfg_wdata       in  (write only)
//
// An item is taken every cycle while item_stall is low; its result passes
// through the input register and then the result queue before it is offered.
// Reset is synchronous and clears all but the payload and queue storage registers.
// item_stall rises only when the input register is full and the result
// queue holds two transactions; it never depends on result_stall directly.
// ----------------------------------------------------------------------------
`default_nettype none

module canopen_sync_producer_consumer_top
  import csync_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   item_valid,
  output logic                        item_stall,
  input  item_t                       item,
  output logic                        result_valid,
  input  wire logic                   result_stall,
  output result_t                     result,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

  cfg_t    cfg;
  logic    queue_full;
  logic    push;
  result_t push_data;

  // Configuration registers.
  csync_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Input register and SYNC logic.
  csync_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .queue_full (queue_full),
    .push       (push),
    .push_data  (push_data)
  );

  // Result queue.
  csync_outq u_outq (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .push_data    (push_data),
    .full         (queue_full),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire

// ===== hdl/csync_cfg.sv =====
// ----------------------------------------------------------------------------
// SYNC configuration registers
// Holds the COB-ID, period and counter overflow and flags a restart of the
// cycle whenever a write changes one of them.
// ----------------------------------------------------------------------------
`default_nettype none

module csync_cfg
  import csync_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
  output cfg_t                        cfg
);

  logic [31:0] sync_cob_id;
  logic [31:0] period_us;
  logic [7:0]  counter_overflow;

  logic [31:0] sync_cob_id_next;
  logic [31:0] period_us_next;
  logic [7:0]  counter_overflow_next;
  logic        restart_next;
  logic [7:0]  ovf_wdata;

  assign ovf_wdata = cfg_wdata[7:0];

  // Decode a write; only a change of value restarts the cycle.
  always_comb begin
    sync_cob_id_next      = sync_cob_id;
    period_us_next        = period_us;
    counter_overflow_next = counter_overflow;
    restart_next          = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_SYNC_COB_ID: begin
          if (cfg_wdata != sync_cob_id) begin
            sync_cob_id_next = cfg_wdata;
            restart_next     = 1'b1;
          end
        end
        REG_PERIOD_US: begin
          if (cfg_wdata != period_us) begin
            period_us_next = cfg_wdata;
            restart_next   = 1'b1;
          end
        end
        REG_COUNTER_OVERFLOW: begin
          // An overflow of one or above the maximum is rejected.
          if (ovf_wdata != counter_overflow && ovf_wdata != 8'd1 &&
              ovf_wdata <= MAX_OVERFLOW) begin
            counter_overflow_next = ovf_wdata;
            restart_next          = 1'b1;
          end
        end
        default: begin
          restart_next = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_cob_id      <= SYNC_COB_ID_RESET;
      period_us        <= '0;
      counter_overflow <= '0;
    end else begin
      sync_cob_id      <= sync_cob_id_next;
      period_us        <= period_us_next;
      counter_overflow <= counter_overflow_next;
    end
  end

  // Decoded view; a standard identifier keeps only its low 11 bits.
  // The restart takes effect at the same edge as the changing write.
  always_comb begin
    cfg.producer = sync_cob_id[COB_PRODUCER_BIT];
    cfg.extended = sync_cob_id[COB_EXTENDED_BIT];
    cfg.can_id   = sync_cob_id[COB_EXTENDED_BIT] ? sync_cob_id[28:0]
                                                 : {18'd0, sync_cob_id[10:0]};
    cfg.period   = period_us;
    cfg.overflow = counter_overflow;
    cfg.restart  = restart_next;
  end

  // The overflow register never holds a rejected value.
  a_ovf_legal: assert property (@(posedge clk) disable iff (rst)
    counter_overflow != 8'd1 && counter_overflow <= MAX_OVERFLOW)
    else $error("counter overflow holds a rejected value");

  // A restart only comes with a configuration write.
  a_restart_cause: assert property (@(posedge clk) disable iff (rst)
    cfg.restart |-> cfg_we)
    else $error("restart without a configuration write");

  // A standard identifier has no bits above bit 10.
  a_std_mask: assert property (@(posedge clk) disable iff (rst)
    !cfg.extended |-> cfg.can_id[28:11] == 18'd0)
    else $error("standard identifier not masked");

endmodule

`default_nettype wire

// ===== hdl/csync_core.sv =====
// ----------------------------------------------------------------------------
// SYNC core
// Input register, tick counter, SYNC counter and the produce/consume logic.
// One registered item is resolved per cycle, while the result queue has room, into zero or one result.
// ----------------------------------------------------------------------------
`default_nettype none

module csync_core
  import csync_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  cfg_t       cfg,
  input  wire logic  item_valid,
  output logic       item_stall,
  input  item_t      item,
  input  wire logic  queue_full,
  output logic       push,
  output result_t    push_data
);

  logic        s1_valid;
  item_t       s1_item;
  logic [31:0] tick_count;
  logic [7:0]  sync_counter;

  logic        s1_valid_next;
  logic [31:0] tick_count_next;
  logic [7:0]  sync_counter_next;

  logic        accept;
  logic        advance;
  logic        is_frame;
  logic        active;
  logic [32:0] count_inc;
  logic        fire;
  logic        has_counter;
  logic        id_match;
  logic        frame_match;
  logic        len_ok;

  // The input register moves on whenever the output queue has room.
  assign advance    = s1_valid && !queue_full;
  assign item_stall = s1_valid && queue_full;
  assign accept     = item_valid && !item_stall;

  assign is_frame    = (s1_item.kind == KIND_FRAME);
  assign active      = cfg.producer && (cfg.period != 32'd0);
  assign has_counter = (cfg.overflow != 8'd0);

  // Tick path: one increment and one compare against the period.
  assign count_inc = {1'b0, tick_count} + 33'd1;
  assign fire      = !is_frame && active && (count_inc >= {1'b0, cfg.period});

  // Frame path: format and identifier match in consumer mode.
  assign id_match = s1_item.frame_extended ?
                    (s1_item.frame_id == cfg.can_id) :
                    (s1_item.frame_id[10:0] == cfg.can_id[10:0]);
  assign frame_match = is_frame && !cfg.producer &&
                       (s1_item.frame_extended == cfg.extended) && id_match;
  assign len_ok      = (s1_item.frame_len == {3'd0, has_counter});

  assign push = advance && (fire || frame_match);

  // Result fields for either kind of result.
  always_comb begin
    push_data = '0;
    if (is_frame) begin
      push_data.result_kind   = RESULT_RECEIVED;
      push_data.counter_value = (has_counter && len_ok) ? s1_item.frame_byte0 : 8'd0;
      push_data.length_error  = !len_ok;
    end else begin
      push_data.result_kind   = RESULT_SENT;
      push_data.out_id        = cfg.can_id;
      push_data.out_extended  = cfg.extended;
      push_data.out_len       = has_counter;
      push_data.counter_value = has_counter ? sync_counter : 8'd0;
    end
  end

  // Next state: a configuration change restarts the cycle.
  always_comb begin
    s1_valid_next     = accept ? 1'b1 : (advance ? 1'b0 : s1_valid);
    tick_count_next   = tick_count;
    sync_counter_next = sync_counter;
    if (cfg.restart) begin
      tick_count_next   = '0;
      sync_counter_next = SYNC_COUNTER_INIT;
    end else if (advance && !is_frame && active) begin
      if (fire) begin
        tick_count_next = '0;
        if (has_counter) begin
          sync_counter_next = (sync_counter < cfg.overflow) ?
                              sync_counter + 8'd1 : SYNC_COUNTER_INIT;
        end
      end else begin
        tick_count_next = count_inc[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      tick_count   <= '0;
      sync_counter <= SYNC_COUNTER_INIT;
    end else begin
      s1_valid     <= s1_valid_next;
      tick_count   <= tick_count_next;
      sync_counter <= sync_counter_next;
    end
  end

  // Payload register; no reset needed.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= item;
    end
  end

  // The tick counter stays below the period while producing.
  a_tick_range: assert property (@(posedge clk) disable iff (rst)
    active |-> tick_count < cfg.period)
    else $error("tick counter reached the period");

  // The SYNC counter never reads zero.
  a_counter_nonzero: assert property (@(posedge clk) disable iff (rst)
    sync_counter != 8'd0)
    else $error("SYNC counter is zero");

  // No result is pushed into a full queue.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    push |-> !queue_full)
    else $error("push into full result queue");

  // A producer only ever sends; a consumer only ever receives.
  a_kind_mode: assert property (@(posedge clk) disable iff (rst)
    push |-> (push_data.result_kind == RESULT_RECEIVED) == !cfg.producer)
    else $error("result kind does not match the mode");

endmodule

`default_nettype wire

// ===== hdl/csync_outq.sv =====
// ----------------------------------------------------------------------------
// SYNC result queue
// Two-entry queue between the core and the result channel, so the input
// side never waits on the result stall within the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module csync_outq
  import csync_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  result_t    push_data,
  output logic       full,
  output logic       result_valid,
  input  wire logic  result_stall,
  output result_t    result
);

  result_t    mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  logic       pop;

  assign pop          = result_valid && !result_stall;
  assign full         = (count == 2'd2);
  assign result_valid = (count != 2'd0);
  assign result       = mem[rd_ptr];

  // Pointer and fill count bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Fill count stays within the depth.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= 2'd2)
    else $error("result queue count out of range");

  // Pointers differ by the fill count.
  a_ptr_count: assert property (@(posedge clk) disable iff (rst)
    (wr_ptr ^ rd_ptr) == count[0])
    else $error("result queue pointers disagree with count");

  // A push without a pop raises the count.
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 2'd1)
    else $error("result queue count did not rise");

endmodule

`default_nettype wire
